[rtl/core/lptc_pkg.sv]
package lptc_pkg;

   typedef enum logic [2:0] {
      KIND_LOOKUP = 3'd0,
      KIND_TRY_INSERT = 3'd1,
      KIND_ALLOCATE = 3'd2,
      KIND_REMOVE = 3'd3,
      KIND_ADD_REF = 3'd4,
      KIND_DROP_REF = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0,
      ST_INVALID_TAG = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_NO_SPACE = 3'd3,
      ST_STILL_REF = 3'd4
   } status_type;

   localparam int TAG_W = 64;
   localparam int KIND_W = 3;
   localparam int STATUS_W = 3;
   localparam int SLOT_W = 4;
   localparam int COUNT_W = 5;

   // controller -> datapath
   typedef struct packed {
      logic load;        // capture request, start compare
      logic scan_start;  // begin victim walk
      logic scan_step;   // advance victim walk one position
      logic commit;      // apply the update and build result
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_done;
   } dp_stat_type;

endpackage

[rtl/core/lptc_datapath.sv]
module lptc_datapath #(
   parameter int ENTRIES = 16,
   parameter int REF_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lptc_pkg::dp_cmd_type          cmd,
   output lptc_pkg::dp_stat_type         stat,
   input  logic [lptc_pkg::KIND_W-1:0]   req_kind,
   input  logic [lptc_pkg::TAG_W-1:0]    req_tag,
   output logic [lptc_pkg::STATUS_W-1:0] res_status,
   output logic [lptc_pkg::SLOT_W-1:0]   res_slot,
   output logic                          res_fill,
   output logic                          res_clear,
   output logic [lptc_pkg::COUNT_W-1:0]  res_used,
   output logic [lptc_pkg::COUNT_W-1:0]  res_pinned
);
   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

   logic [lptc_pkg::TAG_W-1:0] tags_ff [ENTRIES];
   logic [ENTRIES-1:0]         valid_ff;
   logic [REF_BITS-1:0]        refs_ff [ENTRIES];
   logic [IW-1:0]              order_ff [ENTRIES]; // position 0 least recent

   logic [lptc_pkg::KIND_W-1:0] kind_ff;
   logic [lptc_pkg::TAG_W-1:0]  tag_ff;
   logic [ENTRIES-1:0]          match_ff;
   logic [IW:0]                 pos_ff;
   logic                        vfound_ff;
   logic [IW-1:0]               vslot_ff;
   logic [CW-1:0]               used_ff, pinned_ff;

   // match vector registered at load
   logic [ENTRIES-1:0] match_in;
   always_comb begin
      for (int i = 0; i < ENTRIES; i++)
         match_in[i] = valid_ff[i] && (tags_ff[i] == req_tag);
   end

   // lowest matching slot
   logic          hit;
   logic [IW-1:0] hit_slot;
   always_comb begin
      hit = 1'b0;
      hit_slot = '0;
      for (int i = ENTRIES - 1; i >= 0; i--)
         if (match_ff[i]) begin
            hit = 1'b1;
            hit_slot = IW'(i);
         end
   end

   logic [IW-1:0] cur_slot;
   logic          cur_free;
   assign cur_slot = order_ff[pos_ff[IW-1:0]];
   assign cur_free = !valid_ff[cur_slot] || (refs_ff[cur_slot] == '0);
   assign stat.scan_done = vfound_ff || (pos_ff == (IW+1)'(ENTRIES));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_kind;
         tag_ff   <= req_tag;
         match_ff <= match_in;
      end
      if (cmd.scan_start) begin
         pos_ff    <= '0;
         vfound_ff <= 1'b0;
      end else if (cmd.scan_step && !stat.scan_done) begin
         if (cur_free) begin
            vfound_ff <= 1'b1;
            vslot_ff  <= cur_slot;
         end else begin
            pos_ff <= pos_ff + 1'b1;
         end
      end
   end

   // commit: decide outcome
   logic          do_alloc, do_hit_mru, do_remove, do_inc, do_dec;
   logic [2:0]    st;
   logic [IW-1:0] tslot;
   always_comb begin
      do_alloc = 1'b0; do_hit_mru = 1'b0; do_remove = 1'b0;
      do_inc = 1'b0; do_dec = 1'b0;
      st = lptc_pkg::ST_OK;
      tslot = hit_slot;
      if (tag_ff == '0 || kind_ff > lptc_pkg::KIND_DROP_REF) begin
         st = lptc_pkg::ST_INVALID_TAG;
      end else if (kind_ff == lptc_pkg::KIND_ALLOCATE ||
                   (kind_ff == lptc_pkg::KIND_TRY_INSERT && !hit)) begin
         if (vfound_ff) begin
            do_alloc = 1'b1;
            tslot = vslot_ff;
         end else begin
            st = lptc_pkg::ST_NO_SPACE;
         end
      end else if (!hit) begin
         st = lptc_pkg::ST_NOT_FOUND;
      end else begin
         case (kind_ff)
            lptc_pkg::KIND_LOOKUP, lptc_pkg::KIND_TRY_INSERT: begin
               do_hit_mru = 1'b1;
               do_inc = 1'b1;
            end
            lptc_pkg::KIND_REMOVE: begin
               if (refs_ff[hit_slot] > REF_BITS'(1)) st = lptc_pkg::ST_STILL_REF;
               else do_remove = 1'b1;
            end
            lptc_pkg::KIND_ADD_REF: do_inc = 1'b1;
            default: do_dec = 1'b1;
         endcase
      end
   end

   logic [IW-1:0] tpos;
   always_comb begin
      tpos = '0;
      for (int p = 0; p < ENTRIES; p++)
         if (order_ff[p] == tslot) tpos = IW'(p);
   end

   // counts of next state, registered at commit
   logic [CW-1:0] used_in, pinned_in;
   always_comb begin
      used_in = used_ff;
      pinned_in = pinned_ff;
      if (do_alloc) begin
         if (!valid_ff[tslot]) used_in = used_ff + 1'b1;
         pinned_in = pinned_ff + 1'b1; // victim had no references
      end else if (do_remove) begin
         used_in = used_ff - 1'b1;
         if (refs_ff[tslot] != '0) pinned_in = pinned_ff - 1'b1;
      end else if (do_inc) begin
         if (refs_ff[tslot] == '0) pinned_in = pinned_ff + 1'b1;
      end else if (do_dec) begin
         if (refs_ff[tslot] == REF_BITS'(1)) pinned_in = pinned_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         used_ff   <= '0;
         pinned_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            refs_ff[i]  <= '0;
            tags_ff[i]  <= '0;
            order_ff[i] <= IW'(ENTRIES - 1 - i);
         end
      end else if (cmd.commit) begin
         used_ff   <= used_in;
         pinned_ff <= pinned_in;
         if (do_alloc) begin
            valid_ff[tslot] <= 1'b1;
            refs_ff[tslot]  <= REF_BITS'(1);
            tags_ff[tslot]  <= tag_ff;
         end
         if (do_remove) begin
            valid_ff[tslot] <= 1'b0;
            refs_ff[tslot]  <= '0;
            tags_ff[tslot]  <= '0;
         end
         if (do_inc && refs_ff[tslot] != REF_MAX) refs_ff[tslot] <= refs_ff[tslot] + 1'b1;
         if (do_dec && refs_ff[tslot] != '0) refs_ff[tslot] <= refs_ff[tslot] - 1'b1;
         if (do_alloc || do_hit_mru) begin
            for (int p = 0; p < ENTRIES - 1; p++)
               if (IW'(p) >= tpos) order_ff[p] <= order_ff[p + 1];
            order_ff[ENTRIES - 1] <= tslot;
         end
         if (do_remove) begin
            for (int p = 1; p < ENTRIES; p++)
               if (IW'(p) <= tpos) order_ff[p] <= order_ff[p - 1];
            order_ff[0] <= tslot;
         end
         res_status <= st;
         res_slot   <= (st == lptc_pkg::ST_OK) ? lptc_pkg::SLOT_W'(tslot) : '0;
         res_fill   <= do_alloc;
         res_clear  <= (do_alloc && valid_ff[tslot]) || do_remove;
         res_used   <= lptc_pkg::COUNT_W'(used_in);
         res_pinned <= lptc_pkg::COUNT_W'(pinned_in);
      end
   end
endmodule

[rtl/core/lptc_ctrl.sv]
module lptc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output lptc_pkg::dp_cmd_type  cmd,
   input  lptc_pkg::dp_stat_type stat
);
   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_COMMIT, S_OUT} state_type;
   state_type state_ff;
   logic      rvalid_ff;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rvalid_ff;

   always_comb begin
      cmd = '0;
      cmd.load = (state_ff == S_IDLE) && req_tvalid;
      cmd.scan_start = cmd.load;
      cmd.scan_step = (state_ff == S_SCAN);
      cmd.commit = (state_ff == S_COMMIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rvalid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: if (req_tvalid) state_ff <= S_SCAN;
            S_SCAN: if (stat.scan_done) state_ff <= S_COMMIT;
            S_COMMIT: begin
               rvalid_ff <= 1'b1;
               state_ff  <= S_OUT;
            end
            S_OUT: if (rsp_tready) begin
               rvalid_ff <= 1'b0;
               state_ff  <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

[rtl/core/lru_pinned_tag_cache_top.sv]
// Flow: a request is accepted in S_IDLE, the victim walk runs in S_SCAN, the update is
// applied in S_COMMIT and the response word is held in S_OUT until taken; the victim
// walk steps one recency position per cycle until an unpinned slot, or through all
// ENTRIES positions when there is none. Throughput: one request at a time; the next
// request is taken the cycle after the response word leaves.
// Reset (synchronous, high): directory empty, refs zero, highest slot least recent.
module lru_pinned_tag_cache_top #(
   parameter int ENTRIES = 16,
   parameter int REF_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // [2:0] kind, [66:3] tag, [71:67] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata   // [2:0] status, [6:3] slot, [7] newly_allocated,
                                   // [8] evicted, [13:9] entries_in_use,
                                   // [18:14] entries_pinned, [23:19] zero
);
   lptc_pkg::dp_cmd_type  cmd;
   lptc_pkg::dp_stat_type stat;
   logic [2:0] st;
   logic [3:0] sl;
   logic       fl, cl;
   logic [4:0] us, pn;

   lptc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .cmd(cmd), .stat(stat)
   );

   lptc_datapath #(.ENTRIES(ENTRIES), .REF_BITS(REF_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_kind(req_tdata[2:0]), .req_tag(req_tdata[66:3]),
      .res_status(st), .res_slot(sl), .res_fill(fl), .res_clear(cl),
      .res_used(us), .res_pinned(pn)
   );

   assign rsp_tdata = {5'd0, pn, us, cl, fl, sl, st};
endmodule

[rtl/core/lptc_checker.sv]
module lptc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while stalled");
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while response pending");
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != 3'd0 |-> rsp_tdata[8:3] == 6'd0)
      else $error("slot or flags set on failed request");
   a_pinned_le_used: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[18:14] <= rsp_tdata[13:9])
      else $error("pinned count exceeds live count");
   a_fill_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[7] |-> rsp_tdata[18:14] != 5'd0)
      else $error("fill with no pinned entry");
endmodule

bind lru_pinned_tag_cache_top lptc_checker u_lptc_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
